// ----- src/sensor_trimmed_mean_scaler_unit_assert.svh -----
// Assertion macros for the trimmed mean scaler checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef SENSOR_TRIMMED_MEAN_SCALER_UNIT_ASSERT_SVH
`define SENSOR_TRIMMED_MEAN_SCALER_UNIT_ASSERT_SVH

// Consequent in the same cycle.
`define STMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stms checker: implication failed");

// Consequent in the next cycle.
`define STMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stms checker: next-cycle implication failed");

`endif

// ----- src/stms_pkg.sv -----
// Shared constants and types of the trimmed mean scaler.
// No dependencies; used by every module of the block.
package stms_pkg;

  localparam int SAMPLES_PER_RESULT = 10;
  localparam int NUM_CH     = 4;
  localparam int CH_SPIN    = 3;
  localparam int SMP_W      = 10;
  localparam int SUM_W      = 16;
  localparam int TRIM_W     = 6;
  localparam int OUT_W      = 11;
  localparam int CTR_W      = 12;
  localparam int CNT_W      = $clog2(SAMPLES_PER_RESULT);
  localparam int CFG_IDX_W  = 2;

  // Trimmed divisor and its reciprocal
  localparam int TRIM_DIV   = SAMPLES_PER_RESULT - 2;
  localparam int DIV_SHIFT  = 22;
  localparam int DIV_RCP_W  = 23;
  localparam longint DIV_RECIP = (64'd1 << DIV_SHIFT) / TRIM_DIV;

  // Centering and 1000/1022 scaling
  localparam int CENTRE_LO   = 511;
  localparam int CENTRE_HI   = 512;
  localparam int SCALE_NUM   = 1000;
  localparam int SCALE_DEN   = 1022;
  localparam int PROD_W      = 20;
  localparam int SCALE_SHIFT = 30;
  localparam int SCALE_RCP_W = 21;
  localparam longint SCALE_RECIP = (64'd1 << SCALE_SHIFT) / SCALE_DEN;

  // Pipeline stage positions
  localparam int ST_KEPT    = 0;
  localparam int ST_QEST    = 1;
  localparam int ST_MEAN    = 2;
  localparam int ST_CTR     = 3;
  localparam int ST_PROD    = 4;
  localparam int ST_SEST    = 5;
  localparam int ST_OUT     = 6;
  localparam int NUM_STAGES = 7;

  localparam int TRIM_X_RST    = 2;
  localparam int TRIM_Y_RST    = 0;
  localparam int TRIM_Z_RST    = 0;
  localparam int TRIM_SPIN_RST = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_TRIM    = 2'd0,
    REG_Y_TRIM    = 2'd1,
    REG_Z_TRIM    = 2'd2,
    REG_SPIN_TRIM = 2'd3
  } cfg_reg_e;

  typedef logic signed [CTR_W-1:0] ctr_t;

  typedef struct packed {
    logic                  acc_en;
    logic                  last;
    logic [NUM_STAGES-1:0] adv;
  } stms_ctrl_t;

endpackage

// ----- src/stms_lane.sv -----
// One channel lane: running sum, min and max, then the trimmed mean.
// Depends on stms_pkg.
module stms_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stms_pkg::stms_ctrl_t           ctrl_i,
  input  logic [stms_pkg::SMP_W-1:0]     sample_i,
  output logic [stms_pkg::SMP_W-1:0]     mean_o
);

  localparam int SW = stms_pkg::SUM_W;
  localparam int MW = stms_pkg::SMP_W;
  localparam int PW = SW + stms_pkg::DIV_RCP_W;

  logic [SW-1:0] sum_q, sum_n;
  logic [MW-1:0] min_q, min_n, max_q, max_n;
  logic [SW-1:0] kept_d, kept_q, kept1_q;
  logic [PW-1:0] qprod;
  logic [MW-1:0] qest_d, qest_q;
  logic [SW-1:0] back, rem;
  logic [MW-1:0] mean_d, mean_q;

  always_comb begin
    sum_n  = sum_q + SW'(sample_i);
    min_n  = (sample_i < min_q) ? sample_i : min_q;
    max_n  = (sample_i > max_q) ? sample_i : max_q;
    kept_d = sum_n - SW'(min_n) - SW'(max_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      min_q <= '1;
      max_q <= '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.last) begin
        sum_q <= '0;
        min_q <= '1;
        max_q <= '0;
      end else begin
        sum_q <= sum_n;
        min_q <= min_n;
        max_q <= max_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[stms_pkg::ST_KEPT]) kept_q <= kept_d;
  end

  assign qprod  = PW'(kept_q) * PW'(stms_pkg::DIV_RECIP);
  assign qest_d = qprod[stms_pkg::DIV_SHIFT +: MW];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[stms_pkg::ST_QEST]) begin
      qest_q  <= qest_d;
      kept1_q <= kept_q;
    end
  end

  always_comb begin
    back   = SW'(qest_q) * SW'(stms_pkg::TRIM_DIV);
    rem    = kept1_q - back;
    mean_d = (rem >= SW'(stms_pkg::TRIM_DIV)) ? qest_q + MW'(1) : qest_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[stms_pkg::ST_MEAN]) mean_q <= mean_d;
  end

  assign mean_o = mean_q;

endmodule

// ----- src/stms_scale.sv -----
// Centering, trim and 1000/1022 scaling of one channel's mean.
// Depends on stms_pkg.
module stms_scale (
  input  logic                                 clk_i,
  input  stms_pkg::stms_ctrl_t                 ctrl_i,
  input  logic                                 spin_i,
  input  logic        [stms_pkg::SMP_W-1:0]    mean_i,
  input  logic signed [stms_pkg::TRIM_W-1:0]   trim_i,
  output logic        [stms_pkg::SMP_W-1:0]    mean_o,
  output logic signed [stms_pkg::OUT_W-1:0]    scaled_o
);

  localparam int MW = stms_pkg::SMP_W;
  localparam int CW = stms_pkg::CTR_W;
  localparam int PW = stms_pkg::PROD_W;
  localparam int EW = PW + stms_pkg::SCALE_RCP_W;
  localparam int OW = stms_pkg::OUT_W;

  stms_pkg::ctr_t trim_x, mean_s, v_acc, c_acc, c_m, c_sp, x;
  logic           neg_d, neg3_q, neg4_q, neg5_q;
  logic [MW-1:0]  mag_d, mag_q;
  logic [MW-1:0]  mean3_q, mean4_q, mean5_q;
  logic [PW-1:0]  prod_d, prod_q, prod5_q;
  logic [EW-1:0]  est_full;
  logic [MW-1:0]  sest_q, q_fin;
  logic [PW-1:0]  back, rem;
  logic [OW-1:0]  q_ext;

  always_comb begin
    trim_x = stms_pkg::ctr_t'({{(CW - stms_pkg::TRIM_W){trim_i[stms_pkg::TRIM_W-1]}}, trim_i});
    mean_s = stms_pkg::ctr_t'({{(CW - MW){1'b0}}, mean_i});
    v_acc  = mean_s + trim_x;
    c_acc  = (v_acc < stms_pkg::ctr_t'(stms_pkg::CENTRE_HI))
             ? v_acc - stms_pkg::ctr_t'(stms_pkg::CENTRE_LO)
             : v_acc - stms_pkg::ctr_t'(stms_pkg::CENTRE_HI);
    c_m    = (mean_s < stms_pkg::ctr_t'(stms_pkg::CENTRE_HI))
             ? mean_s - stms_pkg::ctr_t'(stms_pkg::CENTRE_LO)
             : mean_s - stms_pkg::ctr_t'(stms_pkg::CENTRE_HI);
    c_sp   = -(c_m + trim_x);
    x      = spin_i ? c_sp : c_acc;
    neg_d  = x[CW-1];
    mag_d  = neg_d ? MW'(-x) : MW'(x);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[stms_pkg::ST_CTR]) begin
      neg3_q  <= neg_d;
      mag_q   <= mag_d;
      mean3_q <= mean_i;
    end
  end

  assign prod_d = PW'(mag_q) * PW'(stms_pkg::SCALE_NUM);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[stms_pkg::ST_PROD]) begin
      prod_q  <= prod_d;
      neg4_q  <= neg3_q;
      mean4_q <= mean3_q;
    end
  end

  assign est_full = EW'(prod_q) * EW'(stms_pkg::SCALE_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[stms_pkg::ST_SEST]) begin
      sest_q  <= est_full[stms_pkg::SCALE_SHIFT +: MW];
      prod5_q <= prod_q;
      neg5_q  <= neg4_q;
      mean5_q <= mean4_q;
    end
  end

  always_comb begin
    back     = PW'(sest_q) * PW'(stms_pkg::SCALE_DEN);
    rem      = prod5_q - back;
    q_fin    = (rem >= PW'(stms_pkg::SCALE_DEN)) ? sest_q + MW'(1) : sest_q;
    q_ext    = OW'(q_fin);
    scaled_o = neg5_q ? $signed(-q_ext) : $signed(q_ext);
  end

  assign mean_o = mean5_q;

endmodule

// ----- src/sensor_trimmed_mean_scaler_unit.sv -----
// Top level of the trimmed mean scaler: four channel lanes and the result register.
// Depends on stms_pkg, stms_lane and stms_scale.
//
// Use: one sample set (X, Y, Z, spin) is a transfer on the input channel. After
// every SAMPLES_PER_RESULT transfers one result is offered on the output
// channel: per channel the mean with minimum and maximum dropped, and the
// centered, trimmed values scaled by 1000/1022.
// Throughput: one sample set per cycle while in_ready_o is high; the accumulators take a set on every transfer.
// Pipeline: the transfer of the last set of a group loads the first of the seven
// divide, center and scale stages, and the result is valid in the last of them.
// Stall: while the receiver holds ready low, results wait in the pipeline stages;
// input keeps flowing unless completing a group would need a full pipeline.
// Configuration: four 6-bit trim registers on the config channel, always ready;
// write them only while the block is idle.
// Reset: accumulators cleared, trims set to 2, 0, 0 and 12, no result pending.
module sensor_trimmed_mean_scaler_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic        [stms_pkg::SMP_W-1:0]      sample_x_i,
  input  logic        [stms_pkg::SMP_W-1:0]      sample_y_i,
  input  logic        [stms_pkg::SMP_W-1:0]      sample_z_i,
  input  logic        [stms_pkg::SMP_W-1:0]      sample_spin_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic        [stms_pkg::SMP_W-1:0]      mean_x_o,
  output logic        [stms_pkg::SMP_W-1:0]      mean_y_o,
  output logic        [stms_pkg::SMP_W-1:0]      mean_z_o,
  output logic        [stms_pkg::SMP_W-1:0]      mean_spin_o,
  output logic signed [stms_pkg::OUT_W-1:0]      accel_x_scaled_o,
  output logic signed [stms_pkg::OUT_W-1:0]      accel_y_scaled_o,
  output logic signed [stms_pkg::OUT_W-1:0]      accel_z_scaled_o,
  output logic signed [stms_pkg::OUT_W-1:0]      spin_rate_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [stms_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [stms_pkg::TRIM_W-1:0]     cfg_data_i
);

  localparam int NS = stms_pkg::NUM_STAGES;
  localparam int NC = stms_pkg::NUM_CH;
  localparam int CW = stms_pkg::CNT_W;

  stms_pkg::stms_ctrl_t ctrl;
  logic [NS-1:0]        v_q, rdy;
  logic [CW-1:0]        count_q;
  logic                 last, in_fire;

  logic        [stms_pkg::SMP_W-1:0]  sample   [NC];
  logic        [stms_pkg::SMP_W-1:0]  lane_mean[NC];
  logic        [stms_pkg::SMP_W-1:0]  sc_mean  [NC];
  logic signed [stms_pkg::OUT_W-1:0]  sc_val   [NC];
  logic signed [stms_pkg::TRIM_W-1:0] trim_q   [NC];
  logic        [stms_pkg::SMP_W-1:0]  mean_q   [NC];
  logic signed [stms_pkg::OUT_W-1:0]  scaled_q [NC];

  assign sample[0] = sample_x_i;
  assign sample[1] = sample_y_i;
  assign sample[2] = sample_z_i;
  assign sample[3] = sample_spin_i;

  assign last       = (count_q == CW'(stms_pkg::SAMPLES_PER_RESULT - 1));
  assign in_ready_o = !last || rdy[0];
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ctrl.acc_en = in_fire;
  assign ctrl.last   = last;
  assign ctrl.adv    = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v_q     <= '0;
    end else begin
      if (in_fire) begin
        count_q <= last ? '0 : count_q + CW'(1);
      end
      if (rdy[0]) v_q[0] <= in_fire && last;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q[0] <= stms_pkg::TRIM_W'(stms_pkg::TRIM_X_RST);
      trim_q[1] <= stms_pkg::TRIM_W'(stms_pkg::TRIM_Y_RST);
      trim_q[2] <= stms_pkg::TRIM_W'(stms_pkg::TRIM_Z_RST);
      trim_q[3] <= stms_pkg::TRIM_W'(stms_pkg::TRIM_SPIN_RST);
    end else if (cfg_valid_i) begin
      case (stms_pkg::cfg_reg_e'(cfg_index_i))
        stms_pkg::REG_X_TRIM:    trim_q[0] <= cfg_data_i;
        stms_pkg::REG_Y_TRIM:    trim_q[1] <= cfg_data_i;
        stms_pkg::REG_Z_TRIM:    trim_q[2] <= cfg_data_i;
        stms_pkg::REG_SPIN_TRIM: trim_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  for (genvar g = 0; g < NC; g++) begin : g_lane
    stms_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (sample[g]),
      .mean_o   (lane_mean[g])
    );

    stms_scale u_scale (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .spin_i   (g == stms_pkg::CH_SPIN),
      .mean_i   (lane_mean[g]),
      .trim_i   (trim_q[g]),
      .mean_o   (sc_mean[g]),
      .scaled_o (sc_val[g])
    );
  end

  // Merge the lanes into the result register
  always_ff @(posedge clk_i) begin
    if (rdy[stms_pkg::ST_OUT]) begin
      for (int c = 0; c < NC; c++) begin
        mean_q[c]   <= sc_mean[c];
        scaled_q[c] <= sc_val[c];
      end
    end
  end

  assign out_valid_o      = v_q[stms_pkg::ST_OUT];
  assign mean_x_o         = mean_q[0];
  assign mean_y_o         = mean_q[1];
  assign mean_z_o         = mean_q[2];
  assign mean_spin_o      = mean_q[3];
  assign accel_x_scaled_o = scaled_q[0];
  assign accel_y_scaled_o = scaled_q[1];
  assign accel_z_scaled_o = scaled_q[2];
  assign spin_rate_o      = scaled_q[3];

endmodule

// ----- src/stms_checker.sv -----
// Port-level checker for the trimmed mean scaler, bound to the top level.
// Depends on stms_pkg and sensor_trimmed_mean_scaler_unit_assert.svh.
`include "sensor_trimmed_mean_scaler_unit_assert.svh"

module stms_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic        [stms_pkg::SMP_W-1:0]      mean_x_o,
  input logic signed [stms_pkg::OUT_W-1:0]      accel_x_scaled_o,
  input logic signed [stms_pkg::OUT_W-1:0]      spin_rate_o
);

  `STMS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `STMS_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(mean_x_o))
  `STMS_ASSERT_IMP(a_in_stall_full, !in_ready_o, out_valid_o && !out_ready_i)
  `STMS_ASSERT_IMP(a_scaled_range, out_valid_o,
      accel_x_scaled_o <= 11'sd600 && accel_x_scaled_o >= -11'sd600 &&
      spin_rate_o <= 11'sd600 && spin_rate_o >= -11'sd600)

endmodule

bind sensor_trimmed_mean_scaler_unit stms_checker u_stms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .mean_x_o         (mean_x_o),
  .accel_x_scaled_o (accel_x_scaled_o),
  .spin_rate_o      (spin_rate_o)
);
